// ===== design/cgp_pkg.sv =====
// cgp_pkg: shared widths, constants and the peak compare for count_grid_peaks.
// No dependencies; used by cgp_cell, cgp_line and count_grid_peaks_top.
package cgp_pkg;

   localparam int MAX_SIDE   = 64;
   localparam int PIXEL_W    = 8;
   localparam int CFG_W      = 7;
   localparam int COUNT_W    = 13;
   localparam int RESET_SIDE = 5;

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

   // Cell holding the pixel one row minus one column back (right neighbor).
   localparam int RIGHT_TAP = (MAX_SIDE >= 2) ? MAX_SIDE - 2 : 0;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [SIDE_W-1:0]  side_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Clamp a written side length into 1..MAX_SIDE.
   function automatic side_type clip_side(input logic [CFG_W-1:0] value);
      side_type result;
      if (value == '0) begin
         result = side_type'(1);
      end else if (int'(value) > MAX_SIDE) begin
         result = side_type'(MAX_SIDE);
      end else begin
         result = side_type'(value);
      end
      return result;
   endfunction

   // Strict four-neighbor maximum.
   function automatic logic is_peak(input pixel_type mid, input pixel_type up,
                                    input pixel_type down, input pixel_type left,
                                    input pixel_type right);
      return (mid > up) && (mid > down) && (mid > left) && (mid > right);
   endfunction

endpackage

// ===== design/cgp_cell.sv =====
// cgp_cell: one pixel stage of the row delay chain.
// Depends on cgp_pkg for the pixel type.
module cgp_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  logic              load,        // this cell is the chain entry point
   input  cgp_pkg::pixel_type new_pixel,
   input  cgp_pkg::pixel_type prev_pixel,
   output cgp_pkg::pixel_type pixel
);

   cgp_pkg::pixel_type pixel_ff;
   cgp_pkg::pixel_type pixel_in;

   always_comb begin
      pixel_in = load ? new_pixel : prev_pixel;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel = pixel_ff;

endmodule

// ===== design/cgp_line.sv =====
// cgp_line: row-length delay line built from a chain of cgp_cell stages.
// Pixels enter at cell MAX_SIDE-side and leave at the far end. Uses cgp_pkg.
module cgp_line (
   input  logic               clock,
   input  logic               shift_en,
   input  cgp_pkg::side_type  side,
   input  cgp_pkg::pixel_type din,
   output cgp_pkg::pixel_type dout,      // din delayed by side requests
   output cgp_pkg::pixel_type dout_early // din delayed by side-1 requests
);

   cgp_pkg::pixel_type            taps [cgp_pkg::MAX_SIDE];
   logic [cgp_pkg::IDX_W-1:0]     entry;

   assign entry = cgp_pkg::IDX_W'(cgp_pkg::side_type'(cgp_pkg::MAX_SIDE) - side);

   for (genvar i = 0; i < cgp_pkg::MAX_SIDE; i++) begin : g_cell
      cgp_pkg::pixel_type prev;
      if (i == 0) begin : g_head
         assign prev = din;
      end else begin : g_body
         assign prev = taps[i-1];
      end
      cgp_cell u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .load       (entry == cgp_pkg::IDX_W'(i)),
         .new_pixel  (din),
         .prev_pixel (prev),
         .pixel      (taps[i])
      );
   end

   assign dout       = taps[cgp_pkg::MAX_SIDE-1];
   assign dout_early = taps[cgp_pkg::RIGHT_TAP];

endmodule

// ===== design/count_grid_peaks_top.sv =====
// count_grid_peaks_top: four-neighbor local maximum counter over a raster grid.
// Throughput: one height request per cycle while the output buffer has room; both
// row delay lines (cell chains) shift once per accepted request.
// A grid's count is registered into the output buffer as its last pixel is accepted.
// A two-entry output buffer lets input continue while one result is stalled.
// Reset (synchronous): side length 5, position and count cleared; delay lines unreset.
module count_grid_peaks_top (
   input  logic        clock,
   input  logic        reset,
   // configuration: side length
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data,     // [6:0] side_length
   // height requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] height
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata     // [12:0] peak_count, [15:13] zero
);

   typedef cgp_pkg::pixel_type pixel_type;

   // ---------------------------------------------------------------------
   // Configuration and position counters
   // ---------------------------------------------------------------------
   cgp_pkg::side_type  side_ff, side_in;
   cgp_pkg::idx_type   row_ff, row_in;
   cgp_pkg::idx_type   col_ff, col_in;
   cgp_pkg::count_type total_ff, total_in;

   logic      accept;
   logic      cfg_write;
   pixel_type height;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid & csr_ready;
   assign accept    = req_tvalid & req_tready;
   assign height    = req_tdata[cgp_pkg::PIXEL_W-1:0];

   cgp_pkg::side_type last_idx;
   logic at_last_col, at_last_row, final_px;
   logic col_ge1, col_ge2, row_ge1, row_ge2, side_ge2;

   assign last_idx    = side_ff - cgp_pkg::side_type'(1);
   assign at_last_col = cgp_pkg::side_type'(col_ff) == last_idx;
   assign at_last_row = cgp_pkg::side_type'(row_ff) == last_idx;
   assign final_px    = at_last_col & at_last_row;
   assign col_ge1     = col_ff != '0;
   assign col_ge2     = col_ff > cgp_pkg::idx_type'(1);
   assign row_ge1     = row_ff != '0;
   assign row_ge2     = row_ff > cgp_pkg::idx_type'(1);
   assign side_ge2    = side_ff > cgp_pkg::side_type'(1);

   // ---------------------------------------------------------------------
   // Pixel window: short taps plus two row delay lines
   //   d1/d2    : one and two pixels back in this row
   //   line_a   : one row back (center), early tap = right neighbor
   //   left_ff  : one row plus one pixel back
   //   line_b   : two rows back (up)
   // ---------------------------------------------------------------------
   pixel_type d1_ff, d2_ff, left_ff;
   pixel_type center, right_px, up2;

   cgp_line u_line_a (
      .clock      (clock),
      .shift_en   (accept),
      .side       (side_ff),
      .din        (height),
      .dout       (center),
      .dout_early (right_px)
   );

   pixel_type unused_early;

   cgp_line u_line_b (
      .clock      (clock),
      .shift_en   (accept),
      .side       (side_ff),
      .din        (center),
      .dout       (up2),
      .dout_early (unused_early)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         d1_ff   <= height;
         d2_ff   <= d1_ff;
         left_ff <= center;
      end
   end

   // ---------------------------------------------------------------------
   // Judgments made on each request
   //   above : cell directly above the arriving pixel
   //   lastl : on the last row, the cell left of the arriving pixel
   //   lastc : on the final pixel, the bottom-right corner itself
   // ---------------------------------------------------------------------
   logic peak_above, peak_lastl, peak_lastc;

   always_comb begin
      peak_above = row_ge1 &&
         cgp_pkg::is_peak(center,
                          row_ge2 ? up2 : '0,
                          height,
                          col_ge1 ? left_ff : '0,
                          at_last_col ? '0 : right_px);
      peak_lastl = at_last_row && col_ge1 &&
         cgp_pkg::is_peak(d1_ff,
                          side_ge2 ? left_ff : '0,
                          '0,
                          col_ge2 ? d2_ff : '0,
                          height);
      peak_lastc = final_px &&
         cgp_pkg::is_peak(height,
                          side_ge2 ? center : '0,
                          '0,
                          col_ge1 ? d1_ff : '0,
                          '0);
   end

   logic [cgp_pkg::COUNT_W:0] sum_wide;
   cgp_pkg::count_type        sum;

   assign sum_wide = {1'b0, total_ff}
                   + (cgp_pkg::COUNT_W+1)'(peak_above)
                   + (cgp_pkg::COUNT_W+1)'(peak_lastl)
                   + (cgp_pkg::COUNT_W+1)'(peak_lastc);
   // saturate, as the count register cannot wrap
   assign sum = sum_wide[cgp_pkg::COUNT_W] ? cgp_pkg::COUNT_MAX
                                           : sum_wide[cgp_pkg::COUNT_W-1:0];

   // ---------------------------------------------------------------------
   // Position / count next state
   // ---------------------------------------------------------------------
   always_comb begin
      side_in  = side_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      total_in = total_ff;
      if (cfg_write) begin
         // new side restarts the grid; delay lines keep their contents
         side_in  = cgp_pkg::clip_side(csr_data);
         row_in   = '0;
         col_in   = '0;
         total_in = '0;
      end else if (accept) begin
         if (at_last_col) begin
            col_in = '0;
            if (at_last_row) begin
               row_in   = '0;
               total_in = '0;
            end else begin
               row_in   = row_ff + cgp_pkg::idx_type'(1);
               total_in = sum;
            end
         end else begin
            col_in   = col_ff + cgp_pkg::idx_type'(1);
            total_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= cgp_pkg::clip_side(cgp_pkg::CFG_W'(cgp_pkg::RESET_SIDE));
         row_ff   <= '0;
         col_ff   <= '0;
         total_ff <= '0;
      end else begin
         side_ff  <= side_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         total_ff <= total_in;
      end
   end

   // ---------------------------------------------------------------------
   // Output buffer: main register plus one skid entry.
   // Input stalls only when both hold unread results.
   // ---------------------------------------------------------------------
   logic               main_valid_ff, main_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   cgp_pkg::count_type main_ff, main_in;
   cgp_pkg::count_type skid_ff, skid_in;
   logic               push, pop;

   assign req_tready = ~skid_valid_ff;
   assign push       = accept & final_px;
   assign pop        = main_valid_ff & rsp_tready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (main_valid_ff) begin
         if (push && pop) begin
            main_in = sum;
         end else if (push) begin
            skid_in       = sum;
            skid_valid_in = 1'b1;
         end else if (pop) begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         main_in       = sum;
         main_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {{(16-cgp_pkg::COUNT_W){1'b0}}, main_ff};

endmodule

// ===== tb/sv/count_grid_peaks_top_tb.sv =====
// count_grid_peaks_top_tb: self-checking bench for the grid peak counter.
// Depends on cgp_pkg and count_grid_peaks_top; predicts each grid's count in a
// scoreboard class and compares it with every result the block returns.
module count_grid_peaks_top_tb;
   import cgp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int CSR_SETTLE  = 4;     // idle cycles before a side write
   localparam int DRAIN_WAIT  = 10;    // cycles after the last count arrives

   // How the heights of one grid are drawn.
   typedef enum int {
      SPREAD_FULL,     // anything 0..255
      SPREAD_TIGHT,    // 0..3, lots of ties
      SPREAD_HIGH,     // 250..255, ties near the top
      SPREAD_SPARSE    // half zeros, half anything
   } spread_kind;

   // Scoreboard: keeps its own copy of the line stores, position and count,
   // and queues one expected count per finished grid.
   class peak_scoreboard;
      logic [CFG_W-1:0] side_reg;
      pixel_type        upper_row[MAX_SIDE];
      pixel_type        live_row[MAX_SIDE];
      int unsigned      row_pos;
      int unsigned      col_pos;
      count_type        running_peaks;
      count_type        expected_counts[$];
      int               errors;

      function new();
         side_reg      = CFG_W'(RESET_SIDE);
         row_pos       = 0;
         col_pos       = 0;
         running_peaks = '0;
         errors        = 0;
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            live_row[i]  = '0;
         end
      endfunction

      function int unsigned grid_side();
         int unsigned s;
         s = side_reg;
         if (s == 0) s = 1;
         if (s > MAX_SIDE) s = MAX_SIDE;
         return s;
      endfunction

      function bit beats(pixel_type mid, pixel_type up, pixel_type down,
                         pixel_type left, pixel_type right);
         return mid > up && mid > down && mid > left && mid > right;
      endfunction

      function void tally_peak();
         if (running_peaks != COUNT_MAX) running_peaks++;
      endfunction

      // Side write restarts the grid; line stores keep their contents.
      function void write_side(logic [CFG_W-1:0] value);
         side_reg      = value;
         row_pos       = 0;
         col_pos       = 0;
         running_peaks = '0;
      endfunction

      function void note_height(pixel_type h);
         int unsigned n, r, c;
         pixel_type   up, left, right;
         n = grid_side();
         if (row_pos >= n || col_pos >= n) begin
            row_pos       = 0;
            col_pos       = 0;
            running_peaks = '0;
         end
         r = row_pos;
         c = col_pos;
         // the arriving height is the down neighbor of the cell above it
         if (r >= 1) begin
            up    = (r >= 2) ? upper_row[c] : '0;
            left  = (c > 0) ? upper_row[c-1] : '0;
            right = (c + 1 < n) ? live_row[c+1] : '0;
            if (beats(live_row[c], up, h, left, right)) tally_peak();
            upper_row[c] = live_row[c];
         end
         live_row[c] = h;
         c++;
         if (c < n) begin
            col_pos = c;
            return;
         end
         col_pos = 0;
         r++;
         if (r < n) begin
            row_pos = r;
            return;
         end
         // last cell: bottom row judged against the zero border
         for (int unsigned k = 0; k < n; k++) begin
            up    = (n >= 2) ? upper_row[k] : '0;
            left  = (k > 0) ? live_row[k-1] : '0;
            right = (k + 1 < n) ? live_row[k+1] : '0;
            if (beats(live_row[k], up, '0, left, right)) tally_peak();
         end
         expected_counts.push_back(running_peaks);
         row_pos       = 0;
         running_peaks = '0;
      endfunction

      function void check_count(count_type got);
         count_type want;
         if (expected_counts.size() == 0) begin
            $display("%0t: unexpected peak count: expected none, actual %0d", $time, got);
            errors++;
            return;
         end
         want = expected_counts.pop_front();
         if (want !== got) begin
            $display("%0t: peak count mismatch: expected %0d, actual %0d",
                     $time, want, got);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_counts.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   peak_scoreboard sb = new();

   int send_idle_pct = 24;   // chance per cycle that no request is offered
   int stall_pct     = 83;   // chance per cycle that the result side stalls
   int heights_sent  = 0;
   int cycle_count   = 0;

   count_grid_peaks_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Result side: ready toggles at the falling edge, counts sampled at the rising edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_count(rsp_tdata[COUNT_W-1:0]);
      end
   end

   // Watchdog: a hung handshake or a missing count ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic pixel_type pick_height(spread_kind spread);
      case (spread)
         SPREAD_TIGHT: return pixel_type'($urandom_range(0, 3));
         SPREAD_HIGH:  return pixel_type'($urandom_range(250, 255));
         SPREAD_SPARSE: begin
            if ($urandom_range(0, 1) == 0) return '0;
            return pixel_type'($urandom_range(0, 255));
         end
         default:      return pixel_type'($urandom_range(0, 255));
      endcase
   endfunction

   // One height request; entered and left at a falling edge.
   task automatic send_height(input pixel_type value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      sb.note_height(value);
      heights_sent++;
      @(negedge clock);
   endtask

   task automatic feed_cells(input int cells, input spread_kind spread);
      repeat (cells) send_height(pick_height(spread));
   endtask

   task automatic wait_for_results();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Side writes only with the block idle; a partial grid leaves no count to
   // wait for, so a short settle always follows the drain.
   task automatic change_side(input logic [6:0] value);
      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (CSR_SETTLE) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_side(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly small whole grids with random content, now and then a grid cut
   // short by the next side write.
   task automatic run_phase(input int quota);
      int          start;
      int          pick;
      int unsigned n;
      logic [6:0]  side_val;
      start = heights_sent;
      while (heights_sent - start < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) side_val = 7'd0;
         else if (pick < 12) side_val = 7'd1;
         else if (pick < 85) side_val = 7'($urandom_range(2, 6));
         else side_val = 7'($urandom_range(7, 12));
         change_side(side_val);
         n = (side_val == 0) ? 1 : side_val;
         repeat ($urandom_range(1, 3)) feed_cells(n * n, spread_kind'($urandom_range(0, 3)));
         if (n > 1 && $urandom_range(0, 3) == 0) begin
            feed_cells($urandom_range(1, n * n - 1), spread_kind'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset side of five: 0/255 checkerboard, every 255 is a peak.
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 5; c++) begin
            send_height(((r + c) % 2 == 0) ? 8'hFF : 8'h00);
         end
      end
      // Side zero acts as one: a lone zero is no peak, a lone 255 is.
      change_side(7'd0);
      send_height(8'h00);
      send_height(8'hFF);
      change_side(7'd1);
      send_height(8'h01);

      // Phase 1: sender idles lightly, result side stalls heavily.
      run_phase(240);
      change_side(7'd64);
      feed_cells(40, SPREAD_FULL);

      // Phase 2: swapped.
      send_idle_pct = 83;
      stall_pct     = 24;
      run_phase(240);
      change_side(7'd65);
      feed_cells(30, SPREAD_SPARSE);

      // Phase 3: no idling; a clamped write opens a partial grid at the widest side.
      send_idle_pct = 0;
      stall_pct     = 0;
      change_side(7'd127);
      feed_cells(30, SPREAD_FULL);
      run_phase(240);

      req_tvalid <= 1'b0;
      wait_for_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/cgp_pkg.sv
design/cgp_cell.sv
design/cgp_line.sv
design/count_grid_peaks_top.sv
tb/sv/count_grid_peaks_top_tb.sv
